>>> sv/assert_macros.svh
// Concurrent assertion helpers; clocked on clk, quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_ALWAYS(lbl, !(expr), msg)

`endif

>>> sv/bfils_pkg.sv
package bfils_pkg;

	localparam int BYTE_W        = 8;
	localparam int CMD_W         = 2;
	localparam int FLAG_W        = 5;
	localparam int LEN_W         = 7;
	localparam int TIMER_W       = 11;
	localparam int MAX_FRAME     = 64;
	localparam int LEN_RESET     = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_W         = 7;
	localparam int IN_TDATA_W    = 16;
	localparam int OUT_TDATA_W   = 32;

	localparam int DEF_RX_DEPTH  = 64;
	localparam int DEF_TX_DEPTH  = 64;
	localparam int DEF_CHAR_BITS = 10;

	// uart_flags bit positions
	localparam int FL_IDLE  = 0;
	localparam int FL_BREAK = 1;
	localparam int FL_RXRDY = 2;
	localparam int FL_FERR  = 3;
	localparam int FL_TXE   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MASTER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN    = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK,
		CMD_WRITE,
		CMD_READ,
		CMD_EVENT
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_BREAK,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [1:0]        link_state;
		logic              tx_irq_enabled;
		logic              wr_accepted;
		logic [BYTE_W-1:0] rd_byte;
		logic              rd_valid;
		logic              notify;
		logic              self_interrupt;
		logic              send_break;
		logic [BYTE_W-1:0] tx_byte;
		logic              tx_valid;
	} bfils_result_t;

	localparam int RESULT_W = $bits(bfils_result_t);

endpackage

>>> sv/bfils_ram.sv
module bfils_ram import bfils_pkg::*; #(
	parameter  int DEPTH = DEF_RX_DEPTH,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/bfils_ctrl.sv
`include "assert_macros.svh"

module bfils_ctrl import bfils_pkg::*; #(
	parameter  int RX_DEPTH  = DEF_RX_DEPTH,
	parameter  int TX_DEPTH  = DEF_TX_DEPTH,
	parameter  int CHAR_BITS = DEF_CHAR_BITS,
	localparam int RX_AW     = $clog2(RX_DEPTH),
	localparam int TX_AW     = $clog2(TX_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_W-1:0]     in_cmd,
	input  logic [BYTE_W-1:0]    in_data,
	input  logic [FLAG_W-1:0]    in_flags,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bfils_result_t        res,
	output logic                 tx_we,
	output logic [TX_AW-1:0]     tx_waddr,
	output logic                 tx_re,
	output logic [TX_AW-1:0]     tx_raddr,
	input  logic [BYTE_W-1:0]    tx_rdata,
	output logic                 rx_we,
	output logic [RX_AW-1:0]     rx_waddr,
	output logic                 rx_re,
	output logic [RX_AW-1:0]     rx_raddr,
	input  logic [BYTE_W-1:0]    rx_rdata,
	output logic [BYTE_W-1:0]    wdata
);

	localparam int RX_CW = $clog2(RX_DEPTH + 1);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);
	localparam int LW    = (TX_CW > LEN_W) ? TX_CW : LEN_W;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] fl);
		if (fl == '0) begin
			return LEN_W'(1);
		end else if (fl > LEN_W'(MAX_FRAME)) begin
			return LEN_W'(MAX_FRAME);
		end
		return fl;
	endfunction

	logic                master_q;
	logic [LEN_W-1:0]    len_q;
	logic [RX_CW-1:0]    rx_cnt_q;
	logic [RX_AW-1:0]    rx_head_q, rx_tail_q;
	logic [TX_CW-1:0]    tx_cnt_q;
	logic [TX_AW-1:0]    tx_head_q, tx_tail_q;
	logic [LEN_W-1:0]    bytes_left_q, bytes_left_d;
	phase_t              phase_q, phase_d;
	logic                txen_q, txen_d;
	logic [TIMER_W-1:0]  timer_q, timer_d;
	logic                running_q, running_d;
	logic                out_valid_q;
	bfils_result_t       res_q, res_d;

	cmd_t                cmd;
	logic                in_acc;
	logic                is_tick, is_wr, is_rd, is_evt;
	logic [LEN_W-1:0]    n;
	logic [7:0]          mult;
	logic [TIMER_W-1:0]  period, tick_t;
	logic                run, wrap, brk_fire, self_irq;
	logic                wr_ok, rd_ok, rx_push, brk_det, in_brk, arm, evt;
	logic [LEN_W-1:0]    arm_len, bl1, bl2;
	logic                en1, svc, tx_pop, tx_done;

	assign cmd      = cmd_t'(in_cmd);
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign is_tick  = in_acc && (cmd == CMD_TICK);
	assign is_wr    = in_acc && (cmd == CMD_WRITE);
	assign is_rd    = in_acc && (cmd == CMD_READ);
	assign is_evt   = in_acc && (cmd == CMD_EVENT);

	assign n        = eff_len(len_q);
	assign mult     = master_q ? 8'((8'(n) + 8'd2) << 1) : 8'(n) + 8'd1;
	assign period   = TIMER_W'(CHAR_BITS) * TIMER_W'(mult);
	assign tick_t   = timer_q + TIMER_W'(1);
	assign run      = master_q || running_q;
	assign wrap     = is_tick && run && (tick_t >= period);
	assign brk_fire = wrap && (master_q || tx_cnt_q != '0);
	assign self_irq = wrap && !brk_fire && (rx_cnt_q != '0);

	assign wr_ok    = is_wr && (tx_cnt_q < TX_CW'(TX_DEPTH));
	assign rd_ok    = is_rd && (rx_cnt_q != '0);

	assign in_brk   = is_evt && (phase_q == PH_BREAK);
	assign arm      = in_brk && (tx_cnt_q != '0);
	assign arm_len  = (LW'(tx_cnt_q) < LW'(n)) ? LEN_W'(tx_cnt_q) : n;
	assign bl1      = arm ? arm_len : bytes_left_q;
	assign en1      = arm || txen_q;
	assign svc      = is_evt && en1 && in_flags[FL_TXE];
	assign tx_pop   = svc && (tx_cnt_q != '0) && (bl1 != '0);
	assign bl2      = tx_pop ? bl1 - LEN_W'(1) : (svc ? '0 : bl1);
	assign tx_done  = svc && (bl2 == '0);
	assign brk_det  = is_evt && in_flags[FL_BREAK] && !master_q;
	assign rx_push  = is_evt && !in_flags[FL_BREAK] && in_flags[FL_RXRDY] &&
	                  !in_flags[FL_FERR] && (rx_cnt_q < RX_CW'(RX_DEPTH));
	assign evt      = is_evt && (rx_cnt_q != '0) && (in_flags[FL_IDLE] || in_brk);

	assign tx_we    = wr_ok;
	assign tx_waddr = tx_tail_q;
	assign tx_re    = tx_pop;
	assign tx_raddr = tx_head_q;
	assign rx_we    = rx_push;
	assign rx_waddr = rx_tail_q;
	assign rx_re    = rd_ok;
	assign rx_raddr = rx_head_q;
	assign wdata    = in_data;

	// link phase
	always_comb begin
		phase_d = phase_q;
		if (brk_fire || self_irq) begin
			phase_d = PH_BREAK;
		end
		if (in_brk) begin
			phase_d = arm ? PH_DATA : PH_IDLE;
		end
		if (brk_det) begin
			phase_d = PH_WAIT;
		end
		if (tx_done) begin
			phase_d = PH_IDLE;
		end
	end

	always_comb begin
		timer_d      = timer_q;
		running_d    = running_q;
		txen_d       = txen_q;
		bytes_left_d = bytes_left_q;
		if (is_tick && run) begin
			timer_d = wrap ? '0 : tick_t;
			if (wrap && !master_q) begin
				running_d = 1'b0;
			end
		end
		if (is_evt) begin
			txen_d       = en1 && !tx_done;
			bytes_left_d = bl2;
		end
		if (brk_det) begin
			timer_d   = '0;
			running_d = 1'b1;
		end
	end

	always_comb begin
		res_d                = '0;
		res_d.tx_valid       = tx_pop;
		res_d.send_break     = brk_fire;
		res_d.self_interrupt = self_irq;
		res_d.notify         = evt;
		res_d.rd_valid       = rd_ok;
		res_d.wr_accepted    = wr_ok;
		res_d.tx_irq_enabled = txen_d;
		res_d.link_state     = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= 1'b0;
			len_q    <= LEN_W'(LEN_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASTER: master_q <= cfg_wdata[0];
				REG_LEN:    len_q    <= cfg_wdata[LEN_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cnt_q     <= '0;
			rx_head_q    <= '0;
			rx_tail_q    <= '0;
			tx_cnt_q     <= '0;
			tx_head_q    <= '0;
			tx_tail_q    <= '0;
			bytes_left_q <= '0;
			phase_q      <= PH_IDLE;
			txen_q       <= 1'b0;
			timer_q      <= '0;
			running_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			txen_q       <= txen_d;
			bytes_left_q <= bytes_left_d;
			timer_q      <= timer_d;
			running_q    <= running_d;
			if (wr_ok) begin
				tx_cnt_q  <= tx_cnt_q + TX_CW'(1);
				tx_tail_q <= (tx_tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + TX_AW'(1);
			end else if (tx_pop) begin
				tx_cnt_q  <= tx_cnt_q - TX_CW'(1);
				tx_head_q <= (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + TX_AW'(1);
			end
			if (rx_push) begin
				rx_cnt_q  <= rx_cnt_q + RX_CW'(1);
				rx_tail_q <= (rx_tail_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + RX_AW'(1);
			end else if (rd_ok) begin
				rx_cnt_q  <= rx_cnt_q - RX_CW'(1);
				rx_head_q <= (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + RX_AW'(1);
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_d;
		end
	end

	// byte fields come straight from the memory read registers
	always_comb begin
		res         = res_q;
		res.tx_byte = res_q.tx_valid ? tx_rdata : '0;
		res.rd_byte = res_q.rd_valid ? rx_rdata : '0;
	end

	assign out_valid = out_valid_q;

	`ASSERT_ALWAYS(a_counts_hold, !in_acc |=> $stable(tx_cnt_q) && $stable(rx_cnt_q), "fifo count moved without a beat")
	`ASSERT_ALWAYS(a_full_write, in_acc && cmd == CMD_WRITE && tx_cnt_q == TX_CW'(TX_DEPTH) |=> !res_q.wr_accepted, "write accepted into full tx fifo")
	`ASSERT_ALWAYS(a_empty_read, in_acc && cmd == CMD_READ && rx_cnt_q == '0 |=> !res_q.rd_valid, "read returned data from empty rx fifo")
	`ASSERT_ALWAYS(a_last_tx_idle, out_valid_q && res_q.tx_valid && !res_q.tx_irq_enabled |-> res_q.link_state == PH_IDLE, "last byte of slot left link busy")

endmodule

>>> sv/break_framed_irda_link_scheduler_core.sv
// channel   | dir | tuser     | tdata (lowest bit up)
// s_*       | in  | cmd       | data_byte, uart_flags
// m_*       | out | -         | tx_valid, tx_byte, send_break, self_interrupt, notify,
//           |     |           | rd_valid, rd_byte, wr_accepted, tx_irq_enabled, link_state
// cfg_*     | in  | -         | index 0 master_mode, index 1 frame_length
//
// One beat per cycle in while s_tready is high; each beat gives its result beat on the next cycle.
// FIFO state sits in two memories with registered reads; control counters are flops.
// Reset clears pointers and counts only, no clearing pass over the memories.
// The result register frees when m_tready is high, so s_tready follows it.
module break_framed_irda_link_scheduler_core import bfils_pkg::*; #(
	parameter int RX_DEPTH  = DEF_RX_DEPTH,
	parameter int TX_DEPTH  = DEF_TX_DEPTH,
	parameter int CHAR_BITS = DEF_CHAR_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte[7:0], uart_flags[12:8]
	input  logic [CMD_W-1:0]       s_tuser,   // cmd[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // tx_valid[0], tx_byte[8:1], send_break[9],
	                                          // self_interrupt[10], notify[11], rd_valid[12],
	                                          // rd_byte[20:13], wr_accepted[21],
	                                          // tx_irq_enabled[22], link_state[24:23]
);

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);

	bfils_result_t      res;
	logic               tx_we, tx_re, rx_we, rx_re;
	logic [TX_AW-1:0]   tx_waddr, tx_raddr;
	logic [RX_AW-1:0]   rx_waddr, rx_raddr;
	logic [BYTE_W-1:0]  tx_rdata, rx_rdata, wdata;

	bfils_ctrl #(
		.RX_DEPTH  (RX_DEPTH),
		.TX_DEPTH  (TX_DEPTH),
		.CHAR_BITS (CHAR_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_data   (s_tdata[BYTE_W-1:0]),
		.in_flags  (s_tdata[BYTE_W+FLAG_W-1:BYTE_W]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res),
		.tx_we     (tx_we),
		.tx_waddr  (tx_waddr),
		.tx_re     (tx_re),
		.tx_raddr  (tx_raddr),
		.tx_rdata  (tx_rdata),
		.rx_we     (rx_we),
		.rx_waddr  (rx_waddr),
		.rx_re     (rx_re),
		.rx_raddr  (rx_raddr),
		.rx_rdata  (rx_rdata),
		.wdata     (wdata)
	);

	bfils_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (wdata),
		.re    (tx_re),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	bfils_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (wdata),
		.re    (rx_re),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	assign m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res};

endmodule
